FILE: rtl/core/sbe_pkg.sv
// shared constants and types for the stack bytecode executor
`timescale 1ns / 1ps

package sbe_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 256;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned DEPTH_W = 9;

	// opcodes, anything else is a no-op
	localparam logic [CMD_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] OP_PRINT = 3'd1;
	localparam logic [CMD_W-1:0] OP_READ  = 3'd2;
	localparam logic [CMD_W-1:0] OP_ADD   = 3'd3;
	localparam logic [CMD_W-1:0] OP_STOP  = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_HALTED = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;  // capture the beat and read the entry under the top
		logic exec;  // execute the captured instruction
	} sbe_ctl_t;

endpackage

FILE: rtl/core/sbe_ctrl.sv
// sequencing state machine for the stack bytecode executor
`timescale 1ns / 1ps

module sbe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output sbe_pkg::sbe_ctl_t ctl
);
	import sbe_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy     = (state_q == S_EXEC);
	assign done     = done_q;
	assign ctl.load = start && !busy;
	assign ctl.exec = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// every accepted beat is executed in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> ctl.exec)
		else $error("accepted beat not executed");

	// execution is followed by exactly one result strobe
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> (done && !ctl.exec))
		else $error("missing result strobe after execution");

	// a result strobe is never repeated back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");
`endif

endmodule

FILE: rtl/core/sbe_datapath.sv
// stack memory, cached top of stack and instruction execution
`timescale 1ns / 1ps

module sbe_datapath #(
	parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbe_pkg::sbe_ctl_t             ctl,
	input  logic [sbe_pkg::CMD_W-1:0]     command,
	input  logic [sbe_pkg::DATA_W-1:0]    operand,
	input  logic                          operand_valid,
	output logic                          print_valid,
	output logic [sbe_pkg::DATA_W-1:0]    print_value,
	output logic [sbe_pkg::STAT_W-1:0]    status,
	output logic                          halted,
	output logic [sbe_pkg::DEPTH_W-1:0]   stack_depth
);
	import sbe_pkg::*;

	localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

	// entries below the top live in the memory, the top itself in tos_q
	logic [DATA_W-1:0] stack_mem_q [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [DATA_W-1:0] tos_q;
	logic [SPW-1:0]    sp_q;
	logic              halt_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] opnd_q;
	logic              opv_q;

	logic [DATA_W-1:0] res_value_q;
	logic              res_valid_q;
	logic [STAT_W-1:0] res_status_q;
	logic              res_halt_q;
	logic [DEPTH_W-1:0] res_depth_q;

	logic [SPW-1:0]    rd_ptr;
	logic [SPW-1:0]    wr_ptr;
	logic [SPW-1:0]    sp_n;
	logic [DATA_W-1:0] tos_n;
	logic              halt_n;
	logic              wr_en;
	logic              push_op;
	logic              prv_n;
	logic [DATA_W-1:0] pv_n;
	logic [STAT_W-1:0] st_n;
	logic [SPW+DEPTH_W-1:0] sp_ext;

	assign rd_ptr = sp_q - SPW'(2);
	assign wr_ptr = sp_q - SPW'(1);
	assign sp_ext = {{DEPTH_W{1'b0}}, sp_n};

	always_comb begin
		sp_n    = sp_q;
		tos_n   = tos_q;
		halt_n  = halt_q;
		wr_en   = 1'b0;
		push_op = 1'b0;
		prv_n   = 1'b0;
		pv_n    = '0;
		st_n    = ST_OK;
		if (halt_q) begin
			st_n = ST_HALTED;
		end else begin
			case (cmd_q)
				OP_PUSH:  push_op = 1'b1;
				OP_READ:  push_op = opv_q;
				OP_PRINT: begin
					if (sp_q == '0) begin
						st_n = ST_EMPTY;
					end else begin
						prv_n = 1'b1;
						pv_n  = tos_q;
						tos_n = rd_data_q;
						sp_n  = sp_q - SPW'(1);
					end
				end
				OP_ADD: begin
					if (sp_q == '0) begin
						st_n = ST_EMPTY;
					end else if (sp_q == SPW'(1)) begin
						// lone entry is consumed and lost
						st_n = ST_EMPTY;
						sp_n = '0;
					end else begin
						tos_n = tos_q + rd_data_q;
						sp_n  = sp_q - SPW'(1);
					end
				end
				OP_STOP:  halt_n = 1'b1;
				default:  ;
			endcase
			if (push_op) begin
				if (sp_q == SP_FULL) begin
					st_n = ST_FULL;
				end else begin
					// spill the old top below the new one
					wr_en = (sp_q != '0);
					tos_n = opnd_q;
					sp_n  = sp_q + SPW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			stack_mem_q[wr_ptr[AW-1:0]] <= tos_q;
		end
		if (ctl.load) begin
			rd_data_q <= stack_mem_q[rd_ptr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			opnd_q <= operand;
			opv_q  <= operand_valid;
		end
		if (ctl.exec) begin
			tos_q        <= tos_n;
			res_value_q  <= pv_n;
			res_valid_q  <= prv_n;
			res_status_q <= st_n;
			res_halt_q   <= halt_n;
			res_depth_q  <= sp_ext[DEPTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			halt_q <= 1'b0;
		end else if (ctl.exec) begin
			sp_q   <= sp_n;
			halt_q <= halt_n;
		end
	end

	assign print_valid = res_valid_q;
	assign print_value = res_value_q;
	assign status      = res_status_q;
	assign halted      = res_halt_q;
	assign stack_depth = res_depth_q;

`ifndef ASSERT_OFF
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_FULL)
		else $error("stack pointer beyond depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> $stable(sp_q))
		else $error("stack changed while halted");
`endif

endmodule

FILE: rtl/core/stack_bytecode_executor.sv
// top level of the stack bytecode executor
`timescale 1ns / 1ps

// Executes one stack instruction per accepted beat (start high while busy is low)
// on a data stack of STACK_DEPTH 64-bit words. Accepting a beat reads the entry
// under the cached top of stack from the single-port stack RAM, and the execute
// cycle that follows executes and registers the result, which appears on the
// result ports with done high for exactly one cycle. busy is high during the
// execute cycle only, so a new beat can be accepted in the same cycle that the
// previous result is shown; the receiver cannot stall. The stack RAM needs no
// clearing after reset. After a stop every further beat still yields a result,
// with status marking it as ignored.
module stack_bytecode_executor #(
	parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [sbe_pkg::CMD_W-1:0]          command,
	input  logic signed [sbe_pkg::DATA_W-1:0]  operand,
	input  logic                               operand_valid,
	output logic                               done,
	output logic                               print_valid,
	output logic signed [sbe_pkg::DATA_W-1:0]  print_value,
	output logic [sbe_pkg::STAT_W-1:0]         status,
	output logic                               halted,
	output logic [sbe_pkg::DEPTH_W-1:0]        stack_depth
);
	import sbe_pkg::*;

	sbe_ctl_t          ctl;
	logic [DATA_W-1:0] pv;

	sbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	sbe_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.command       (command),
		.operand       (operand),
		.operand_valid (operand_valid),
		.print_valid   (print_valid),
		.print_value   (pv),
		.status        (status),
		.halted        (halted),
		.stack_depth   (stack_depth)
	);

	assign print_value = pv;

endmodule
